/* design/qtrs_pkg.sv */
`default_nettype none

package qtrs_pkg;

	// field widths
	localparam int QW       = 16;            // quaternion component, Q1.14
	localparam int SW       = 32;            // position and scale, Q16.16
	localparam int PW       = 2 * QW;        // component product, Q2.28
	localparam int RW       = PW + 2;        // rotation entry, 28 fraction bits
	localparam int MW       = RW + SW;       // scaled entry, 44 fraction bits
	localparam int ROT_FRAC = 28;
	localparam int NAXIS    = 3;

	localparam logic signed [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_MIN = {1'b1, {(SW-1){1'b0}}};

	typedef logic signed [QW-1:0] quat_t;
	typedef logic signed [SW-1:0] word_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [RW-1:0] rot_t;
	typedef logic signed [MW-1:0] mul_t;

	// squares and cross products of the quaternion components
	typedef struct packed {
		prod_t xx;
		prod_t yy;
		prod_t zz;
		prod_t xy;
		prod_t xz;
		prod_t yz;
		prod_t xw;
		prod_t yw;
		prod_t zw;
	} prods_t;

	// rotation entries, index is column * 3 + row
	typedef logic [NAXIS*NAXIS-1:0][RW-1:0] rot_mat_t;

	// one vector of three Q16.16 words
	typedef logic [NAXIS-1:0][SW-1:0] vec3_t;

	// twice a product, sign extended to the rotation width
	function automatic rot_t dbl_ext(input prod_t p);
		return {{(RW-PW-1){p[PW-1]}}, p, 1'b0};
	endfunction

	// floor shift to Q16.16 and clamp to the signed word range
	function automatic word_t sat_q16(input mul_t v);
		mul_t s;
		s = v >>> ROT_FRAC;
		if ((&s[MW-1:SW-1]) || !(|s[MW-1:SW-1]))
			return s[SW-1:0];
		else if (s[MW-1])
			return SAT_MIN;
		else
			return SAT_MAX;
	endfunction

endpackage

`default_nettype wire

/* design/qtrs_products.sv */
`default_nettype none

module qtrs_products import qtrs_pkg::*; (
	input  wire logic   clk,
	input  wire logic   en,
	input  wire quat_t  qx,
	input  wire quat_t  qy,
	input  wire quat_t  qz,
	input  wire quat_t  qw,
	output prods_t      prods_s1
);

	// nine 16x16 products, each exact in 32 bits
	always_ff @(posedge clk) begin
		if (en) begin
			prods_s1.xx <= prod_t'(qx) * prod_t'(qx);
			prods_s1.yy <= prod_t'(qy) * prod_t'(qy);
			prods_s1.zz <= prod_t'(qz) * prod_t'(qz);
			prods_s1.xy <= prod_t'(qx) * prod_t'(qy);
			prods_s1.xz <= prod_t'(qx) * prod_t'(qz);
			prods_s1.yz <= prod_t'(qy) * prod_t'(qz);
			prods_s1.xw <= prod_t'(qx) * prod_t'(qw);
			prods_s1.yw <= prod_t'(qy) * prod_t'(qw);
			prods_s1.zw <= prod_t'(qz) * prod_t'(qw);
		end
	end

endmodule

`default_nettype wire

/* design/qtrs_rotation.sv */
`default_nettype none

module qtrs_rotation import qtrs_pkg::*; (
	input  wire logic   clk,
	input  wire logic   en,
	input  wire prods_t prods_s1,
	output rot_mat_t    rot_s2
);

	localparam rot_t ROT_ONE = rot_t'(1) <<< ROT_FRAC;

	rot_t xx2, yy2, zz2, xy2, xz2, yz2, xw2, yw2, zw2;

	always_comb begin
		xx2 = dbl_ext(prods_s1.xx);
		yy2 = dbl_ext(prods_s1.yy);
		zz2 = dbl_ext(prods_s1.zz);
		xy2 = dbl_ext(prods_s1.xy);
		xz2 = dbl_ext(prods_s1.xz);
		yz2 = dbl_ext(prods_s1.yz);
		xw2 = dbl_ext(prods_s1.xw);
		yw2 = dbl_ext(prods_s1.yw);
		zw2 = dbl_ext(prods_s1.zw);
	end

	// standard quaternion rotation matrix, column major
	always_ff @(posedge clk) begin
		if (en) begin
			rot_s2[0] <= ROT_ONE - yy2 - zz2;
			rot_s2[1] <= xy2 + zw2;
			rot_s2[2] <= xz2 - yw2;
			rot_s2[3] <= xy2 - zw2;
			rot_s2[4] <= ROT_ONE - xx2 - zz2;
			rot_s2[5] <= yz2 + xw2;
			rot_s2[6] <= xz2 + yw2;
			rot_s2[7] <= yz2 - xw2;
			rot_s2[8] <= ROT_ONE - xx2 - yy2;
		end
	end

endmodule

`default_nettype wire

/* design/qtrs_lane.sv */
`default_nettype none

module qtrs_lane import qtrs_pkg::*; (
	input  wire logic   clk,
	input  wire logic   en3,
	input  wire logic   en4,
	input  wire rot_t   rot,
	input  wire word_t  scale,
	output word_t       res_s4
);

	mul_t mul_s3;

	// rotation entry times axis scale, 34x32
	always_ff @(posedge clk) begin
		if (en3) begin
			mul_s3 <= mul_t'(rot) * mul_t'(scale);
		end
	end

	// back to Q16.16 with saturation
	always_ff @(posedge clk) begin
		if (en4) begin
			res_s4 <= sat_q16(mul_s3);
		end
	end

endmodule

`default_nettype wire

/* design/quaternion_trs_matrix.sv */
// channel   direction  handshake              payload
// request   in         in_valid / in_stall    quat_x..quat_w, pos_x..pos_z, scale_x..scale_z
// result    out        out_valid / out_stall  m_row0_col0 .. m_row2_col3
//
// four register stages: products, rotation sums, scale multiply, shift and clamp
// one request per cycle while in_stall is low; a taken request passes the stages in order
// the 34x32 scale multiply sets the depth of the longest stage
// arst_n clears the stage valid bits only; the datapath carries no reset
// each stage holds while the next one is full and stalled, empty stages fill up

`default_nettype none

module quaternion_trs_matrix import qtrs_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire quat_t        quat_x,
	input  wire quat_t        quat_y,
	input  wire quat_t        quat_z,
	input  wire quat_t        quat_w,
	input  wire word_t        pos_x,
	input  wire word_t        pos_y,
	input  wire word_t        pos_z,
	input  wire word_t        scale_x,
	input  wire word_t        scale_y,
	input  wire word_t        scale_z,
	output logic              out_valid,
	input  wire logic         out_stall,
	output word_t             m_row0_col0,
	output word_t             m_row1_col0,
	output word_t             m_row2_col0,
	output word_t             m_row0_col1,
	output word_t             m_row1_col1,
	output word_t             m_row2_col1,
	output word_t             m_row0_col2,
	output word_t             m_row1_col2,
	output word_t             m_row2_col2,
	output word_t             m_row0_col3,
	output word_t             m_row1_col3,
	output word_t             m_row2_col3
);

	logic     vld_s1, vld_s2, vld_s3, vld_s4;
	logic     en1, en2, en3, en4;
	prods_t   prods_s1;
	rot_mat_t rot_s2;
	vec3_t    scale_s1, scale_s2;
	vec3_t    pos_s1, pos_s2, pos_s3, pos_s4;
	logic [NAXIS*NAXIS-1:0][SW-1:0] res_s4;

	// stage load enables: a stage moves when it is empty or the next one moves
	always_comb begin
		en4      = !vld_s4 || !out_stall;
		en3      = !vld_s3 || en4;
		en2      = !vld_s2 || en3;
		en1      = !vld_s1 || en2;
		in_stall = !en1;
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
		end
	end

	// scale and translation ride alongside
	always_ff @(posedge clk) begin
		if (en1) begin
			scale_s1 <= {scale_z, scale_y, scale_x};
			pos_s1   <= {pos_z, pos_y, pos_x};
		end
		if (en2) begin
			scale_s2 <= scale_s1;
			pos_s2   <= pos_s1;
		end
		if (en3) pos_s3 <= pos_s2;
		if (en4) pos_s4 <= pos_s3;
	end

	qtrs_products u_products (
		.clk      (clk),
		.en       (en1),
		.qx       (quat_x),
		.qy       (quat_y),
		.qz       (quat_z),
		.qw       (quat_w),
		.prods_s1 (prods_s1)
	);

	qtrs_rotation u_rotation (
		.clk      (clk),
		.en       (en2),
		.prods_s1 (prods_s1),
		.rot_s2   (rot_s2)
	);

	// one multiply and clamp lane per rotation entry
	for (genvar c = 0; c < NAXIS; c++) begin : g_col
		for (genvar r = 0; r < NAXIS; r++) begin : g_row
			qtrs_lane u_lane (
				.clk    (clk),
				.en3    (en3),
				.en4    (en4),
				.rot    (rot_s2[c*NAXIS+r]),
				.scale  (scale_s2[c]),
				.res_s4 (res_s4[c*NAXIS+r])
			);
		end
	end

	assign out_valid   = vld_s4;
	assign m_row0_col0 = res_s4[0];
	assign m_row1_col0 = res_s4[1];
	assign m_row2_col0 = res_s4[2];
	assign m_row0_col1 = res_s4[3];
	assign m_row1_col1 = res_s4[4];
	assign m_row2_col1 = res_s4[5];
	assign m_row0_col2 = res_s4[6];
	assign m_row1_col2 = res_s4[7];
	assign m_row2_col2 = res_s4[8];
	assign m_row0_col3 = pos_s4[0];
	assign m_row1_col3 = pos_s4[1];
	assign m_row2_col3 = pos_s4[2];

	// back pressure only when every stage is full and the output is stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && out_stall))
		else $error("request stalled with a free stage");

	// a taken request lands in the first stage
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_s1)
		else $error("taken request lost at stage one");

	// a held stage keeps its request
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !en3) |=> vld_s2)
		else $error("held request dropped at stage two");

	// translation leaves with the request that carried it
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(en4 && vld_s3) |=> (m_row0_col3 == $past(pos_s3[0])))
		else $error("translation out of step with its request");

endmodule

`default_nettype wire
